[design/upd_pkg.sv]
// Package for the url percent decoder: character codes, escape phases,
// the result bundle passed from front to back, and hex digit helpers.
// No dependencies.
package upd_pkg;

  // character codes
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;

  // bundle queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);

  // escape tracking
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_e;

  // up to three result bytes caused by one input byte
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] chars;
    logic            term;   // last byte of the bundle is the terminator
  } upd_bundle_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } upd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic dig, low, upp;
    dig = (c >= 8'h30) && (c <= 8'h39);
    low = (c >= 8'h61) && (c <= 8'h66);
    upp = (c >= 8'h41) && (c <= 8'h46);
    return dig || low || upp;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

endpackage

[design/upd_if.sv]
// Channel interfaces of the url percent decoder: encoded byte input and
// decoded byte output, each with valid/ready handshake.
// No dependencies.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_char, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input string_end,
                  output ready);
endinterface

[design/upd_front.sv]
// Front end: accepts encoded bytes, tracks the escape phase and turns each
// byte into a bundle of zero to three result bytes.
// Depends on upd_pkg and upd_if.
module upd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  upd_in_if.sink               in_i,
  input  upd_pkg::upd_qstat_t  qstat_i,
  output logic                 push_o,
  output upd_pkg::upd_bundle_t bundle_o
);

  upd_pkg::upd_phase_e phase_q, phase_d;
  logic [7:0]          held_q, held_d;
  logic                accept;
  logic [7:0]          c;
  logic                c_hex;
  logic                f_emit;
  logic [7:0]          f_char;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_char;
  assign c_hex      = upd_pkg::is_hex(c);

  // byte handled with no escape pending
  always_comb begin
    f_emit = (c != upd_pkg::CharPct);
    f_char = (c == upd_pkg::CharPlus) ? upd_pkg::CharSpace : c;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept) begin
      unique case (phase_q)
        upd_pkg::PH_PCT: begin
          if (c_hex) begin
            phase_d = upd_pkg::PH_DIGIT;
            held_d  = c;
          end else begin
            phase_d = (c == upd_pkg::CharPct) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            held_d  = '0;
          end
        end
        upd_pkg::PH_DIGIT: begin
          if (c_hex) begin
            phase_d = upd_pkg::PH_IDLE;
          end else begin
            phase_d = (c == upd_pkg::CharPct) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
          end
          held_d = '0;
        end
        default: begin
          phase_d = (c == upd_pkg::CharPct) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
          held_d  = '0;
        end
      endcase
    end
  end

  // result bundle for the current byte
  always_comb begin
    bundle_o      = '0;
    bundle_o.term = (c == upd_pkg::CharNul);
    unique case (phase_q)
      upd_pkg::PH_PCT: begin
        if (!c_hex) begin
          bundle_o.chars[0] = upd_pkg::CharPct;
          bundle_o.chars[1] = f_char;
          bundle_o.cnt      = 2'd1 + {1'b0, f_emit};
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (c_hex) begin
          bundle_o.chars[0] = {upd_pkg::hex_val(held_q), upd_pkg::hex_val(c)};
          bundle_o.cnt      = 2'd1;
        end else begin
          bundle_o.chars[0] = upd_pkg::CharPct;
          bundle_o.chars[1] = held_q;
          bundle_o.chars[2] = f_char;
          bundle_o.cnt      = 2'd2 + {1'b0, f_emit};
        end
      end
      default: begin
        bundle_o.chars[0] = f_char;
        bundle_o.cnt      = {1'b0, f_emit};
      end
    endcase
  end

  assign push_o = accept && (bundle_o.cnt != 2'd0);

  // phase and held digit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

[design/upd_queue.sv]
// Short bundle queue between the front end and the output serializer.
// Depends on upd_pkg.
module upd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  upd_pkg::upd_bundle_t push_data_i,
  input  logic                 pop_i,
  output upd_pkg::upd_bundle_t head_o,
  output upd_pkg::upd_qstat_t  stat_o
);

  upd_pkg::upd_bundle_t         mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QAddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::QAddrW:0]     cnt_q;
  logic                         do_push, do_pop;

  assign stat_o.full  = (cnt_q == (upd_pkg::QAddrW+1)'(upd_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[design/upd_back.sv]
// Back end: takes bundles from the queue and sends their bytes out one
// transaction at a time, marking the last byte of each bundle.
// Depends on upd_pkg and upd_if.
module upd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  upd_pkg::upd_bundle_t head_i,
  input  upd_pkg::upd_qstat_t  qstat_i,
  output logic                 pop_o,
  upd_out_if.source            out_o
);

  upd_pkg::upd_bundle_t cur_q, cur_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [1:0]           idx_q, idx_d;
  logic                 take, last, load;

  assign last = (idx_q == (cur_q.cnt - 2'd1));
  assign take = out_o.valid && out_o.ready;
  assign load = !cur_valid_q || (take && last);
  assign pop_o = load && !qstat_i.empty;

  // output fields from the held bundle
  assign out_o.valid      = cur_valid_q;
  assign out_o.out_char   = cur_q.chars[idx_q];
  assign out_o.run_last   = last;
  assign out_o.string_end = last && cur_q.term;

  // advance within a bundle or load the next one
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_d       = head_i;
      cur_valid_d = !qstat_i.empty;
      idx_d       = '0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  // bundle payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // serializer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

[design/url_percent_decoder.sv]
// Streaming URL percent decoder. One encoded byte is taken per cycle while
// the four-entry bundle queue has room; each byte yields zero to three
// decoded bytes, which leave one per cycle while the receiver is ready and
// bundles are waiting, so the output port sets the sustained rate. A byte
// passes the queue storage and the back-end bundle register on its way out.
// Depends on upd_pkg, upd_if, upd_front, upd_queue and upd_back.
module url_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  logic                 q_push, q_pop;
  upd_pkg::upd_bundle_t q_wdata, q_head;
  upd_pkg::upd_qstat_t  q_stat;

  upd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .qstat_i  (q_stat),
    .push_o   (q_push),
    .bundle_o (q_wdata)
  );

  upd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .qstat_i (q_stat),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // no bundle is offered to a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("bundle pushed into full queue");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_stat.empty))
    else $error("pop from empty queue");

  // the terminator always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.string_end |-> out_o.run_last && (out_o.out_char == 8'h00))
    else $error("terminator not last of run or not zero");

  // an input accepted into an empty system reaches the output via the queue and the back-end bundle register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_push && q_stat.empty && !out_o.valid |-> ##2 out_o.valid)
    else $error("bundle lost between queue and output");

endmodule

[sim/url_percent_decoder_tb.sv]
// Self-checking testbench for url_percent_decoder: random and directed byte strings,
// a bytewise decode predictor and in-order checking of every decoded transaction.
// Depends on upd_pkg, upd_in_if, upd_out_if and the url_percent_decoder design.
module url_percent_decoder_tb;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 180;
  localparam int HoldCycles = 120;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiLowerA = 8'h61;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       term;
  } dec_byte_t;

  typedef struct {
    logic [7:0] ch;
    int         gap;
    bit         drain;
  } feed_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // encoded bytes waiting to be offered, decoded bytes waiting to arrive
  feed_item_t feed_q[$];
  dec_byte_t  decoded_q[$];

  // predictor state
  upd_pkg::upd_phase_e esc_phase = upd_pkg::PH_IDLE;
  logic [7:0] held_digit = 8'h00;

  int mismatches = 0;
  int cycles = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int strings_ended = 0;
  int escapes_decoded = 0;
  int escapes_broken = 0;
  int holds_done = 0;

  // clock
  always #5 clk_i = ~clk_i;

  // {is hex digit, value} of one byte
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= AsciiZero && c < AsciiZero + 8'd10) return {1'b1, 4'(c - AsciiZero)};
    if (c >= AsciiUpperA && c < AsciiUpperA + 8'd6) return {1'b1, 4'(c - AsciiUpperA + 8'd10)};
    if (c >= AsciiLowerA && c < AsciiLowerA + 8'd6) return {1'b1, 4'(c - AsciiLowerA + 8'd10)};
    return 5'b0;
  endfunction

  // work out the decoded bytes caused by one encoded byte
  task automatic decode_byte(input logic [7:0] c);
    dec_byte_t  burst[$];
    logic [4:0] lo_nib;
    logic [4:0] hi_nib;
    bit         fresh;
    fresh = 1'b0;
    lo_nib = nibble_of(c);
    hi_nib = nibble_of(held_digit);
    case (esc_phase)
      upd_pkg::PH_PCT: begin
        if (lo_nib[4]) begin
          held_digit = c;
          esc_phase = upd_pkg::PH_DIGIT;
        end else begin
          burst.push_back('{ch: upd_pkg::CharPct, last: 1'b0, term: 1'b0});
          escapes_broken++;
          fresh = 1'b1;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (lo_nib[4]) begin
          burst.push_back('{ch: {hi_nib[3:0], lo_nib[3:0]}, last: 1'b0, term: 1'b0});
          escapes_decoded++;
          esc_phase = upd_pkg::PH_IDLE;
          held_digit = 8'h00;
        end else begin
          burst.push_back('{ch: upd_pkg::CharPct, last: 1'b0, term: 1'b0});
          burst.push_back('{ch: held_digit, last: 1'b0, term: 1'b0});
          escapes_broken++;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    // the byte is taken as if no escape were pending
    if (fresh) begin
      esc_phase = upd_pkg::PH_IDLE;
      held_digit = 8'h00;
      if (c == upd_pkg::CharNul) begin
        burst.push_back('{ch: upd_pkg::CharNul, last: 1'b0, term: 1'b1});
        strings_ended++;
      end else if (c == upd_pkg::CharPct) begin
        esc_phase = upd_pkg::PH_PCT;
      end else if (c == upd_pkg::CharPlus) begin
        burst.push_back('{ch: upd_pkg::CharSpace, last: 1'b0, term: 1'b0});
      end else begin
        burst.push_back('{ch: c, last: 1'b0, term: 1'b0});
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) decoded_q.push_back(burst[i]);
  endtask

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] n;
    n = 4'($urandom);
    if (n < 4'd10) return AsciiZero + 8'(n);
    if ($urandom_range(0, 1) == 1) return AsciiUpperA + 8'(n) - 8'd10;
    return AsciiLowerA + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c = 8'($urandom_range(1, 255));
      nib = nibble_of(c);
    end while (nib[4]);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] ch, input bit calm, input bit drain = 1'b0);
    feed_item_t it;
    it.ch = ch;
    it.gap = pick_gap(calm);
    it.drain = drain;
    feed_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
  endtask

  // random strings: mostly well-formed text and escapes, some broken escapes and noise
  task automatic build_random();
    int  count;
    int  len;
    int  r;
    bit  calm;
    bit  drain;
    count = 0;
    drain = 1'b1;
    while (count < RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          push_byte(8'($urandom_range(1, 255)), calm, drain);
          count++;
        end else if (r < 52) begin
          push_byte(upd_pkg::CharPlus, calm, drain);
          count++;
        end else if (r < 82) begin
          push_byte(upd_pkg::CharPct, calm, drain);
          push_byte(hex_char(), calm);
          push_byte(hex_char(), calm);
          count += 3;
        end else if (r < 94) begin
          push_byte(upd_pkg::CharPct, calm, drain);
          count++;
          if ($urandom_range(0, 1) == 1) begin
            push_byte(hex_char(), calm);
            count++;
          end
          if ($urandom_range(0, 9) < 7) begin
            push_byte(non_hex_char(), calm);
            count++;
          end
        end else begin
          push_byte(8'($urandom_range(0, 255)), calm, drain);
          count++;
        end
        // sender pauses for a full drain at the start and halfway
        drain = (count >= RandomItems / 2 && count < RandomItems / 2 + 3);
      end
      push_byte(upd_pkg::CharNul, calm);
      count++;
    end
  endtask

  // driver: offers queued bytes with random gaps, holds a transaction until accepted
  int  gap_cnt;
  bit  loaded;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.in_char <= 8'h00;
      gap_cnt = 0;
      loaded = 1'b0;
    end else begin
      nxt_valid = in_ch.valid && !in_ch.ready;
      if (!nxt_valid) begin
        if (!loaded && feed_q.size() > 0) begin
          gap_cnt = feed_q[0].gap;
          loaded = 1'b1;
        end
        if (loaded) begin
          if (gap_cnt > 0) begin
            gap_cnt--;
          end else if (!feed_q[0].drain || (!in_ch.valid && decoded_q.size() == 0)) begin
            in_ch.in_char <= feed_q[0].ch;
            feed_q.pop_front();
            loaded = 1'b0;
            nxt_valid = 1'b1;
          end
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // receiver: random stalls in changing modes, plus two long holds
  int stall_cnt;
  int hold_cnt;
  int mode;
  int mode_cnt;
  int taken;
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
      mode = 0;
      mode_cnt = 0;
      taken = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) taken++;
      mode_cnt++;
      if (mode_cnt == 64) begin
        mode_cnt = 0;
        mode = $urandom_range(0, 2);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if ((holds_done == 0 && taken >= 30) || (holds_done == 1 && taken >= 100)) begin
        hold_cnt = HoldCycles;
        holds_done++;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (mode != 0) begin
          if (r < 20) stall_cnt = $urandom_range(1, 3);
          else if (r < 23) stall_cnt = $urandom_range(8, 30);
        end
      end
    end
  end

  // monitor: check the output transaction, then predict from the input transaction
  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        bytes_out++;
        if (decoded_q.size() == 0) begin
          $error("unexpected output transaction: out_char %02h", out_ch.out_char);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_char !== want.ch) begin
            $error("out_char: expected %02h, got %02h", want.ch, out_ch.out_char);
            mismatches++;
          end
          if (out_ch.run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
            mismatches++;
          end
          if (out_ch.string_end !== want.term) begin
            $error("string_end: expected %0b, got %0b", want.term, out_ch.string_end);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_in++;
        decode_byte(in_ch.in_char);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d decoded bytes outstanding", cycles,
               decoded_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_char = 8'h00;
    out_ch.ready = 1'b0;
    rst_ni = 1'b0;

    // directed: extreme escapes, decoded zero, plus, high bytes, broken escapes, terminators
    push_text("%41%fF%00+");
    push_byte(8'hFF, 1'b1);
    push_byte(upd_pkg::CharPct, 1'b1);
    push_byte(8'hC6, 1'b1);
    push_text("%a%bC%9");
    push_byte(upd_pkg::CharNul, 1'b1);
    push_byte(upd_pkg::CharPct, 1'b1);
    push_byte(upd_pkg::CharNul, 1'b1);
    push_byte(upd_pkg::CharNul, 1'b1);
    build_random();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_q.size() > 0 || in_ch.valid) @(posedge clk_i);
    while (decoded_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d encoded bytes in, %0d decoded bytes out, %0d strings ended",
             bytes_in, bytes_out, strings_ended);
    $display("escapes decoded %0d, escapes broken %0d, long output holds %0d",
             escapes_decoded, escapes_broken, holds_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
